/* sv/odo_pkg.sv */
// ----------------------------------------------------------------------------
// Odometry package
// Shared constants, codes, control types and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package odo_pkg;

  // Default number of CORDIC rotations and its legal range.
  localparam int TrigStepsDefault = 16;
  localparam int TrigStepsMax     = 32;
  localparam int IterW            = 5;

  // Operation codes of an input item.
  localparam logic [1:0] OpStep    = 2'd0;
  localparam logic [1:0] OpCorrect = 2'd1;
  localparam logic [1:0] OpReplace = 2'd2;

  // Configuration register indexes.
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegDistPerTick = 8'd0;
  localparam logic [CfgIdxW-1:0] RegTurnPerTick = 8'd1;
  localparam logic [CfgIdxW-1:0] RegLinGain     = 8'd2;
  localparam logic [CfgIdxW-1:0] RegAngGain     = 8'd3;

  // Register reset values.
  localparam logic [31:0] DistPerTickReset = 32'd731184;
  localparam logic [31:0] TurnPerTickReset = 32'd2140012;

  // CORDIC start vector, gain compensated, Q4.30.
  localparam logic signed [33:0] CordicStart = 34'sd652032874;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_in;
    logic             delta;
    logic             mul;
    logic             scale;
    logic             rot_init;
    logic             rot_step;
    logic [IterW-1:0] iter;
    logic             posmul;
    logic             update;
    logic             load_out;
  } odo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_step;
    logic out_full;
  } odo_status_t;

  // Rotation angles atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] arc_turn(input logic [IterW-1:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;  5'd31: r = 32'h00000000;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/odo_ifs.sv */
// ----------------------------------------------------------------------------
// Odometry channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface odo_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] count_left;
  logic signed [31:0] count_right;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  logic [15:0]        value_heading;
  modport source (output valid, operation, count_left, count_right, value_x, value_y,
                  value_heading, input ready);
  modport sink (input valid, operation, count_left, count_right, value_x, value_y,
                value_heading, output ready);
endinterface

interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface odo_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/odo_ctrl.sv */
// ----------------------------------------------------------------------------
// Odometry controller
// Sequences one item at a time through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_ctrl
  import odo_pkg::*;
#(
  parameter int TRIG_STEPS = TrigStepsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  odo_status_t status_i,
  output odo_cmd_t    cmd_o
);

  localparam int CntW = (TRIG_STEPS > 1) ? $clog2(TRIG_STEPS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(TRIG_STEPS - 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDelta  = 3'd1;
  localparam logic [2:0] StMul    = 3'd2;
  localparam logic [2:0] StScale  = 3'd3;
  localparam logic [2:0] StRot    = 3'd4;
  localparam logic [2:0] StPosMul = 3'd5;
  localparam logic [2:0] StUpdate = 3'd6;
  localparam logic [2:0] StOut    = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == StIdle);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.iter = IterW'(cnt_q);
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = StDelta;
        end
      end
      StDelta: begin
        if (status_i.is_step) begin
          cmd_o.delta    = 1'b1;
          cmd_o.rot_init = 1'b1;
          state_d = StMul;
        end else begin
          state_d = StUpdate;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d = StScale;
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        cnt_d   = '0;
        state_d = StRot;
      end
      StRot: begin
        cmd_o.rot_step = 1'b1;
        if (cnt_q == CntLast) begin
          state_d = StPosMul;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StPosMul: begin
        cmd_o.posmul = 1'b1;
        state_d = StUpdate;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!status_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* sv/odo_dp.sv */
// ----------------------------------------------------------------------------
// Odometry datapath
// Pose state, configuration registers, multipliers and the CORDIC unit.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_dp
  import odo_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  odo_cmd_t           cmd_i,
  output odo_status_t        status_o,
  // Input item fields.
  input  wire [1:0]          operation_i,
  input  wire signed [31:0]  count_left_i,
  input  wire signed [31:0]  count_right_i,
  input  wire signed [31:0]  value_x_i,
  input  wire signed [31:0]  value_y_i,
  input  wire [15:0]         value_heading_i,
  // Configuration writes.
  input  wire                cfg_we_i,
  input  wire [CfgIdxW-1:0]  cfg_index_i,
  input  wire [31:0]         cfg_data_i,
  // Result register.
  input  wire                out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [15:0]        heading_o
);

  // Configuration registers.
  logic [31:0]        dpt_q, tpt_q;
  logic signed [16:0] lin_adj_q, ang_adj_q;

  // Latched item.
  logic [1:0]  op_q;
  logic [31:0] cl_q, cr_q, vx_q, vy_q;
  logic [15:0] vh_q;

  // Pose and previous counts.
  logic [31:0] last_l_q, last_r_q, x_q, y_q;
  logic [15:0] hd_q;

  // Intermediate values of a step.
  logic               neg_q;
  logic [31:0]        mag_q;
  logic signed [32:0] sum_q;
  logic [63:0]        prod_q;
  logic [47:0]        turn_q;
  logic signed [33:0] ds_q;
  logic [15:0]        dh_q;
  logic [31:0]        dx_q, dy_q;

  // CORDIC state.
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [1:0]         quad_q;

  logic               out_valid_q;

  // Combinational helpers.
  logic signed [32:0] dl, dr, diff;
  logic [31:0]        ang;
  logic [1:0]         quad;
  logic [48:0]        dm;
  logic signed [31:0] dist_sat;
  logic signed [17:0] lin_gain, ang_gain;
  logic signed [49:0] dist_gain;
  logic [47:0]        turn_gain;
  logic [47:0]        turn_rnd;
  logic signed [33:0] cos_v, sin_v, sh_x, sh_y;
  logic signed [67:0] px, py;
  logic [31:0]        arc;

  function automatic logic [31:0] count_left_q_wrap(input logic [31:0] a,
                                                    input logic [31:0] b);
    return a - b;
  endfunction

  assign status_o.is_step  = (op_q == OpStep);
  assign status_o.out_full = out_valid_q && !out_ready_i;

  // Count deltas with 32-bit wrap.
  assign dl   = 33'($signed(count_left_q_wrap(cl_q, last_l_q)));
  assign dr   = 33'($signed(count_left_q_wrap(cr_q, last_r_q)));
  assign diff = dl - dr;

  // Gain factors, one plus the adjustment.
  assign lin_gain = 18'sd65536 + 18'(lin_adj_q);
  assign ang_gain = 18'sd65536 + 18'(ang_adj_q);

  // Distance rounding, saturation and linear gain.
  assign dm   = 49'(prod_q >> 16) + 49'(prod_q[15]);
  assign dist_sat = (dm > 49'h7FFFFFFF) ? (neg_q ? -32'sh7FFFFFFF : 32'sh7FFFFFFF)
                                        : (neg_q ? -$signed(dm[31:0]) : $signed(dm[31:0]));
  assign dist_gain = 50'(dist_sat) * 50'(lin_gain);

  // Heading change, 2^-48 turn units, rounded half up.
  assign turn_gain = 48'(turn_q * 48'($unsigned(ang_gain)));
  assign turn_rnd  = (48'd0 - turn_gain) + 48'h0000_8000_0000;

  // Heading to quadrant and residual.
  assign ang  = {hd_q, 16'd0};
  assign quad = 2'((ang + 32'h20000000) >> 30);

  // CORDIC shifts for the current rotation.
  assign sh_x = cx_q >>> cmd_i.iter;
  assign sh_y = cy_q >>> cmd_i.iter;
  assign arc  = arc_turn(cmd_i.iter);

  // Quadrant applied exactly.
  always_comb begin
    unique case (quad_q)
      2'd0: begin cos_v = cx_q;  sin_v = cy_q;  end
      2'd1: begin cos_v = -cy_q; sin_v = cx_q;  end
      2'd2: begin cos_v = -cx_q; sin_v = -cy_q; end
      default: begin cos_v = cy_q; sin_v = -cx_q; end
    endcase
  end

  assign px = 68'(ds_q) * 68'(cos_v) + 68'sd536870912;
  assign py = 68'(ds_q) * 68'(sin_v) + 68'sd536870912;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpt_q     <= DistPerTickReset;
      tpt_q     <= TurnPerTickReset;
      lin_adj_q <= '0;
      ang_adj_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegDistPerTick: dpt_q     <= cfg_data_i;
        RegTurnPerTick: tpt_q     <= cfg_data_i;
        RegLinGain:     lin_adj_q <= $signed(cfg_data_i[16:0]);
        RegAngGain:     ang_adj_q <= $signed(cfg_data_i[16:0]);
        default: ;
      endcase
    end
  end

  // Pose state and stored counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q <= '0;
      last_r_q <= '0;
      x_q      <= '0;
      y_q      <= '0;
      hd_q     <= '0;
    end else begin
      if (cmd_i.delta) begin
        last_l_q <= cl_q;
        last_r_q <= cr_q;
      end
      if (cmd_i.update) begin
        unique case (op_q)
          OpStep: begin
            x_q  <= x_q + dx_q;
            y_q  <= y_q + dy_q;
            hd_q <= hd_q + dh_q;
          end
          OpCorrect: begin
            x_q  <= x_q + vx_q;
            y_q  <= y_q + vy_q;
            hd_q <= hd_q + vh_q;
          end
          OpReplace: begin
            x_q  <= vx_q;
            y_q  <= vy_q;
            hd_q <= vh_q;
          end
          default: ;
        endcase
      end
    end
  end

  // Latched item and step intermediates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OpStep;
    end else if (cmd_i.load_in) begin
      op_q <= operation_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cl_q <= count_left_i;
      cr_q <= count_right_i;
      vx_q <= value_x_i;
      vy_q <= value_y_i;
      vh_q <= value_heading_i;
    end
    if (cmd_i.delta) begin
      neg_q <= diff[32];
      mag_q <= diff[32] ? 32'(-diff) : diff[31:0];
      sum_q <= dl + dr;
    end
    if (cmd_i.mul) begin
      prod_q <= 64'(mag_q) * 64'(dpt_q);
      turn_q <= 48'($unsigned(48'(sum_q)) * 48'(tpt_q));
    end
    if (cmd_i.scale) begin
      ds_q <= 34'((dist_gain + 50'sd32768) >>> 16);
      dh_q <= turn_rnd[47:32];
    end
    if (cmd_i.rot_init) begin
      quad_q <= quad;
      cz_q   <= 34'($signed(ang - {quad, 30'd0}));
      cx_q   <= CordicStart;
      cy_q   <= '0;
    end else if (cmd_i.rot_step) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - sh_y;
        cy_q <= cy_q + sh_x;
        cz_q <= cz_q - $signed({2'b00, arc});
      end else begin
        cx_q <= cx_q + sh_y;
        cy_q <= cy_q - sh_x;
        cz_q <= cz_q + $signed({2'b00, arc});
      end
    end
    if (cmd_i.posmul) begin
      dx_q <= px[61:30];
      dy_q <= py[61:30];
    end
  end

  // Result register, holds the pose until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pos_x_o   <= x_q;
      pos_y_o   <= y_q;
      heading_o <= hd_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* sv/differential_drive_odometry_top.sv */
// ----------------------------------------------------------------------------
// Differential drive odometry
// Dead-reckoning pose tracker for a two-wheel robot, fixed point.
// ----------------------------------------------------------------------------
//  Channel  Dir  Carries
//  in_i     in   operation, encoder counts, pose values
//  out_o    out  pos_x, pos_y, heading
//  cfg_i    in   register index and data
//
// An encoder step runs the delta, multiply, scale, CORDIC rotation, position
// multiply, update and output states; other items go from delta to update and
// output. The next item can be accepted in the cycle the result is presented.
// A waiting result does not stop the next item from being accepted, but a
// second result that finds it still waiting holds the controller and the input.
// Configuration writes are taken in any cycle.
// Reset is asynchronous, clears the pose and counts and restores the registers.
`default_nettype none

module differential_drive_odometry_top
  import odo_pkg::*;
#(
  parameter int TRIG_STEPS = TrigStepsDefault
) (
  input wire  clk_i,
  input wire  rst_ni,
  odo_in_if.sink    in_i,
  odo_out_if.source out_o,
  odo_cfg_if.sink   cfg_i
);

  odo_cmd_t    cmd;
  odo_status_t status;
  logic        in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  odo_ctrl #(
    .TRIG_STEPS(TRIG_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  odo_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .operation_i     (in_i.operation),
    .count_left_i    (in_i.count_left),
    .count_right_i   (in_i.count_right),
    .value_x_i       (in_i.value_x),
    .value_y_i       (in_i.value_y),
    .value_heading_i (in_i.value_heading),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .pos_x_o         (out_o.pos_x),
    .pos_y_o         (out_o.pos_y),
    .heading_o       (out_o.heading)
  );

  // One item at a time: no acceptance right after an acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("item accepted while busy");

  // A new result appears only at the end of an item's work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_ready))
    else $error("result without item");

  // A step command only issues for an encoder step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.delta |-> status.is_step)
    else $error("step work on non-step item");

endmodule

`default_nettype wire

/* test/odo_checker.sv */
// ----------------------------------------------------------------------------
// Odometry result checker
// Watches the item, result and configuration channels. It keeps its own copy
// of the pose, counts and registers, predicts the pose after every accepted
// item and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module odo_checker
  import odo_pkg::*;
#(
  parameter int TRIG_STEPS = TrigStepsDefault
) (
  input wire         clk_i,
  input wire         rst_ni,
  odo_in_if.sink     in_mon,
  odo_out_if.sink    out_mon,
  odo_cfg_if.sink    cfg_mon,
  output int         errors_o,
  output int         pending_o
);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
  } pose_t;

  // Predicted poses, oldest first.
  pose_t pose_q[$];

  // Shadow registers and state.
  logic [31:0] dist_per_tick, turn_per_tick;
  logic [16:0] lin_adj, ang_adj;
  logic [31:0] last_left, last_right;
  pose_t       pose;

  assign pending_o = pose_q.size();

  // Floor shift of a signed value.
  function automatic longint asr(input longint v, input int s);
    return v >>> s;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  // Gain factor 1 + adjustment in Q16.
  function automatic longint gain_of(input logic [16:0] adj);
    return 64'sd65536 + longint'($signed(adj));
  endfunction

  // CORDIC sine and cosine in Q2.30 of a heading.
  task automatic rotate_heading(input logic [15:0] h, output longint c, output longint s);
    logic [31:0] ang, red;
    logic [1:0]  quad;
    longint      z, x, y, dx, dy;
    ang  = {h, 16'h0};
    quad = 2'((ang + 32'h20000000) >> 30);
    red  = ang - ({30'd0, quad} << 30);
    z    = longint'($signed(red));
    x    = CordicStart;
    y    = 0;
    for (int i = 0; i < TRIG_STEPS && i < 32; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(arc_turn(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(arc_turn(5'(i)));
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // Dead-reckoning advance of the pose by one encoder sample.
  task automatic advance_pose(input logic [31:0] left, input logic [31:0] right);
    longint dl, dr, diff, dist_m, ds, c, s;
    logic [63:0] mag, dm, t, p;
    dl   = longint'($signed(left - last_left));
    dr   = longint'($signed(right - last_right));
    diff = dl - dr;
    mag  = diff < 0 ? 64'(-diff) : 64'(diff);
    dm   = (mag * {32'd0, dist_per_tick} + 64'h8000) >> 16;
    last_left  = left;
    last_right = right;
    if (dm > 64'h7FFFFFFF) dm = 64'h7FFFFFFF;
    dist_m = diff < 0 ? -longint'(dm) : longint'(dm);
    ds   = asr(dist_m * gain_of(lin_adj) + 64'sh8000, 16);
    rotate_heading(pose.heading, c, s);
    pose.pos_x += 32'(asr(ds * c + (64'sd1 <<< 29), 30));
    pose.pos_y += 32'(asr(ds * s + (64'sd1 <<< 29), 30));
    t = 64'(dl + dr) * {32'd0, turn_per_tick};
    p = 64'd0 - t * 64'(gain_of(ang_adj));
    pose.heading += 16'((p + 64'h80000000) >> 32);
  endtask

  // Prediction on item beats, register shadowing and result comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    pose_t got, want;
    if (!rst_ni) begin
      dist_per_tick = DistPerTickReset;
      turn_per_tick = TurnPerTickReset;
      lin_adj    = '0;
      ang_adj    = '0;
      last_left  = '0;
      last_right = '0;
      pose       = '0;
      errors_o   = 0;
      pose_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.pos_x, out_mon.pos_y, out_mon.heading};
        if (pose_q.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 0);
        end else begin
          want = pose_q.pop_front();
          if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
          if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
          if (got.heading !== want.heading)
            report_mismatch("heading", got.heading, want.heading);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.operation)
          OpStep: advance_pose(in_mon.count_left, in_mon.count_right);
          OpCorrect: begin
            pose.pos_x   += in_mon.value_x;
            pose.pos_y   += in_mon.value_y;
            pose.heading += in_mon.value_heading;
          end
          OpReplace: pose = '{in_mon.value_x, in_mon.value_y, in_mon.value_heading};
          default: ;
        endcase
        pose_q = {pose_q, pose};
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          RegDistPerTick: dist_per_tick = cfg_mon.data;
          RegTurnPerTick: turn_per_tick = cfg_mon.data;
          RegLinGain:     lin_adj = cfg_mon.data[16:0];
          RegAngGain:     ang_adj = cfg_mon.data[16:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* test/tb_differential_drive_odometry_top.sv */
// ----------------------------------------------------------------------------
// Differential drive odometry testbench
// Drives directed and random items through several register settings with
// random idling on both sides; a checker beside the block predicts and
// compares every pose result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_differential_drive_odometry_top;
  import odo_pkg::*;

  // Operation code with no meaning; the block returns the pose unchanged.
  localparam logic [1:0] OpUnused = 2'd3;

  logic clk_i;
  logic rst_ni;
  int   errors, pending;
  bit   no_idle;
  logic [31:0] enc_left, enc_right;

  odo_in_if  in_ch();
  odo_out_if out_ch();
  odo_cfg_if cfg_ch();

  differential_drive_odometry_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch), .cfg_i(cfg_ch)
  );

  odo_checker pose_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .errors_o(errors), .pending_o(pending)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // Result side stalls at random, except in the quiet stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = no_idle || ($urandom_range(99) >= 36);
    end
  end

  // Sends one item beat, after a random gap.
  task automatic send_item(input logic [1:0] op, input logic [31:0] cl, input logic [31:0] cr,
                           input logic [31:0] vx, input logic [31:0] vy, input logic [15:0] vh);
    while (!no_idle && $urandom_range(99) < 36) @(negedge clk_i);
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.count_left = cl;
    in_ch.count_right = cr;
    in_ch.value_x = vx;
    in_ch.value_y = vy;
    in_ch.value_heading = vh;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  // Waits until every result is in, then for the block to settle.
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // Writes one register.
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // Random encoder sample: mostly small motion, sometimes a wild jump.
  task automatic random_step();
    if ($urandom_range(9) == 0) begin
      enc_left  = $urandom;
      enc_right = $urandom;
    end else begin
      enc_left  += 32'($signed($urandom_range(400)) - 200);
      enc_right += 32'($signed($urandom_range(400)) - 200);
    end
    send_item(OpStep, enc_left, enc_right, $urandom, $urandom, 16'($urandom));
  endtask

  // One random item of any kind, steps dominating.
  task automatic random_item();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) random_step();
    else if (sel < 90)
      send_item(OpCorrect, $urandom, $urandom, 32'($signed($urandom_range(131072)) - 65536),
                32'($signed($urandom_range(131072)) - 65536), 16'($urandom));
    else if (sel < 97)
      send_item(OpReplace, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
    else send_item(OpUnused, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
  endtask

  // Stimulus.
  initial begin
    rst_ni = 1'b0;
    no_idle = 1'b0;
    enc_left = '0;
    enc_right = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OpStep;
    in_ch.count_left = '0;
    in_ch.count_right = '0;
    in_ch.value_x = '0;
    in_ch.value_y = '0;
    in_ch.value_heading = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegDistPerTick;
    cfg_ch.data = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: first step from zero counts, then the operations and extremes.
    send_item(OpStep, 32'd100, -32'sd100, 32'd0, 32'd0, 16'd0);
    send_item(OpStep, 32'd100, 32'd100, 32'd0, 32'd0, 16'd0);
    send_item(OpCorrect, 32'd0, 32'd0, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
    send_item(OpCorrect, 32'd0, 32'd0, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
    send_item(OpUnused, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_item(OpReplace, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 32'd0, 16'h4000);
    send_item(OpStep, 32'h7FFFFFFF, 32'h80000000, 32'd0, 32'd0, 16'd0);
    send_item(OpStep, 32'h80000000, 32'h7FFFFFFF, 32'd0, 32'd0, 16'd0);
    send_item(OpReplace, 32'd0, 32'd0, 32'h80000000, 32'h7FFFFFFF, 16'h8000);
    send_item(OpStep, 32'hFFFFFFFF, 32'h00000000, 32'd0, 32'd0, 16'd0);
    send_item(OpReplace, 32'd0, 32'd0, 32'd0, 32'd0, 16'hC000);
    send_item(OpStep, 32'h00001000, 32'hFFFFF000, 32'd0, 32'd0, 16'd0);
    send_item(OpReplace, 32'd0, 32'd0, 32'd0, 32'd0, 16'h2000);
    send_item(OpStep, 32'h00002000, 32'hFFFFF000, 32'd0, 32'd0, 16'd0);
    enc_left = 32'h00002000;
    enc_right = 32'hFFFFF000;

    // Extreme and random register settings, written while idle.
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(RegDistPerTick, 32'hFFFFFFFF); write_reg(RegTurnPerTick, 32'hFFFFFFFF);
          write_reg(RegLinGain, 32'h0000FFFF);     write_reg(RegAngGain, 32'h0000FFFF);
        end
        1: begin
          write_reg(RegDistPerTick, 32'd0);        write_reg(RegTurnPerTick, 32'd0);
          write_reg(RegLinGain, 32'h00010000);     write_reg(RegAngGain, 32'h00010000);
        end
        5: begin
          write_reg(RegDistPerTick, DistPerTickReset);
          write_reg(RegTurnPerTick, TurnPerTickReset);
          write_reg(RegLinGain, 32'd0);            write_reg(RegAngGain, 32'd0);
        end
        default: begin
          write_reg(RegDistPerTick, $urandom);     write_reg(RegTurnPerTick, $urandom);
          write_reg(RegLinGain, $urandom);         write_reg(RegAngGain, $urandom);
        end
      endcase
      if (phase == 3) no_idle = 1'b1;
      for (int n = 0; n < 310; n++) begin
        random_item();
        if (n == 150) drain();
      end
      no_idle = 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
